### hw/rtl/pdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_pkg: shared types and constants of the picture directory lookup
// Request/response payloads, controller/datapath command and status groups,
// function and register codes, directory geometry.
// ----------------------------------------------------------------------------
package pdl_pkg;

  localparam int DIR_DEPTH     = 256;
  localparam int ADDR_W        = $clog2(DIR_DEPTH);
  localparam int CNT_W         = $clog2(DIR_DEPTH + 1);
  localparam int ENTRY_COUNT_W = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 9;

  localparam logic [15:0] TRANSPARENT_MASK = 16'd1;
  localparam logic [7:0]  OPAQUE_COLOR     = 8'hFF;
  localparam int          TCOLOR_LSB       = 12;

  // Directory row: id, width, height, flags, data offset, palette offset
  localparam int ROW_W = 16 + 16 + 16 + 16 + 24 + 24;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_LOOKUP = 1'b1
  } pdl_func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT = 1'b0,
    REG_PALETTE_EN  = 1'b1
  } pdl_reg_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  slot;
    logic [15:0] pic_id;
    logic [15:0] load_width;
    logic [15:0] load_height;
    logic [15:0] load_flags;
    logic [23:0] load_data_offset;
    logic [23:0] load_palette_offset;
  } pdl_req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] entry_flags;
    logic [23:0] data_offset;
    logic [23:0] palette_offset;
    logic [7:0]  transparent_color;
  } pdl_rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] flags;
    logic [23:0] data_offset;
    logic [23:0] palette_offset;
  } pdl_row_t;

  // Controller -> datapath
  typedef struct packed {
    logic write;      // store request payload as a directory row
    logic init;       // open search window [0, count) and latch key
    logic issue;      // read row at midpoint of current window
    logic step;       // narrow window by last compare, read next midpoint
    logic load_hit;   // capture response from the probed row
    logic load_miss;  // capture all-zero response
  } pdl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic range_nonempty;  // current window holds at least one row
    logic next_nonempty;   // window after this compare holds a row
    logic key_eq;          // probed id equals key
  } pdl_sts_t;

endpackage

### hw/rtl/pdl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module pdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/pdl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_dpath: directory store and search datapath
// Config registers, directory RAM, search window, compare and response reg.
// ----------------------------------------------------------------------------
module pdl_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pdl_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pdl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  pdl_pkg::pdl_req_t                req,
  input  pdl_pkg::pdl_cmd_t                cmd,
  output pdl_pkg::pdl_sts_t                sts,
  output pdl_pkg::pdl_rsp_t                rsp
);
  import pdl_pkg::*;

  logic [ENTRY_COUNT_W-1:0] entry_count;
  logic                     palette_en;

  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  mid;
  logic [15:0]       key;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  mid_cur;
  logic [CNT_W-1:0]  lo_next;
  logic [CNT_W-1:0]  hi_next;
  logic [CNT_W-1:0]  mid_next;
  logic [CNT_W-1:0]  rd_mid;
  logic              key_gt;

  logic              wr_en;
  pdl_row_t          wr_row;
  pdl_row_t          rd_row;
  logic [ROW_W-1:0]  rd_bits;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      palette_en  <= 1'b0;
    end else if (cfg_we) begin
      unique case (pdl_reg_t'(cfg_idx))
        REG_ENTRY_COUNT: entry_count <= ENTRY_COUNT_W'(cfg_data);
        REG_PALETTE_EN:  palette_en  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp count to the directory depth
  assign count = (32'(entry_count) > DIR_DEPTH) ? CNT_W'(DIR_DEPTH)
                                                : CNT_W'(entry_count);

  // Window arithmetic
  assign mid_cur  = lo + ((hi - lo) >> 1);
  assign key_gt   = rd_row.id < key;
  assign lo_next  = key_gt ? (mid + CNT_W'(1)) : lo;
  assign hi_next  = key_gt ? hi : mid;
  assign mid_next = lo_next + ((hi_next - lo_next) >> 1);
  assign rd_mid   = cmd.step ? mid_next : mid_cur;

  assign sts.range_nonempty = hi > lo;
  assign sts.next_nonempty  = hi_next > lo_next;
  assign sts.key_eq         = rd_row.id == key;

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      lo  <= '0;
      hi  <= count;
      key <= req.pic_id;
    end else if (cmd.step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (cmd.issue || cmd.step) begin
      mid <= rd_mid;
    end
  end

  // Directory store
  assign wr_en  = cmd.write && (32'(req.slot) < DIR_DEPTH);
  assign wr_row = '{id:             req.pic_id,
                    width:          req.load_width,
                    height:         req.load_height,
                    flags:          req.load_flags,
                    data_offset:    req.load_data_offset,
                    palette_offset: req.load_palette_offset};
  assign rd_row = pdl_row_t'(rd_bits);

  pdl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DIR_DEPTH)
  ) u_dir_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ADDR_W'(req.slot)),
    .wdata (ROW_W'(wr_row)),
    .re    (cmd.issue || cmd.step),
    .raddr (ADDR_W'(rd_mid)),
    .rdata (rd_bits)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (cmd.load_hit) begin
      rsp.found          <= 1'b1;
      rsp.width          <= rd_row.width;
      rsp.height         <= rd_row.height;
      rsp.entry_flags    <= rd_row.flags;
      rsp.data_offset    <= rd_row.data_offset;
      rsp.palette_offset <= palette_en ? rd_row.palette_offset : 24'd0;
      rsp.transparent_color <= ((rd_row.flags & TRANSPARENT_MASK) != 16'd0)
                               ? {4'd0, rd_row.flags[TCOLOR_LSB +: 4]}
                               : OPAQUE_COLOR;
    end else if (cmd.load_miss) begin
      rsp <= '0;
    end
  end

endmodule

### hw/rtl/pdl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_ctrl: search controller
// Sequences load, search probes and response handoff; owns both handshakes.
// ----------------------------------------------------------------------------
module pdl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  output logic              out_valid,
  input  logic              out_ready,
  input  pdl_pkg::pdl_sts_t sts,
  output pdl_pkg::pdl_cmd_t cmd
);
  import pdl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SEEK = 3'b010,
    S_CMP  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (func == FUNC_LOOKUP) begin
            cmd.init   = 1'b1;
            state_next = S_SEEK;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_SEEK: begin
        if (sts.range_nonempty) begin
          cmd.issue  = 1'b1;
          state_next = S_CMP;
        end else if (out_free) begin
          cmd.load_miss = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_CMP: begin
        if (sts.key_eq) begin
          if (out_free) begin
            cmd.load_hit = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (sts.next_nonempty) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.load_miss = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_hit || cmd.load_miss) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A response is captured only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_hit || cmd.load_miss) |-> (!out_valid || out_ready))
    else $error("response captured over an untaken response");

  // A lookup request always opens a search in the following cycle
  a_lookup_seeks: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_LOOKUP) |=> state == S_SEEK)
    else $error("lookup request did not start a search");

  // Step only into a non-empty window, and never past an equal compare
  a_step_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (sts.next_nonempty && !sts.key_eq))
    else $error("search stepped into an empty window or past a hit");

  // A stalled result holds the search in place
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && sts.key_eq && out_valid && !out_ready) |=> state == S_CMP)
    else $error("search left compare while the output was stalled");

endmodule

### hw/rtl/picture_directory_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picture_directory_lookup_top: sorted picture directory with binary search
// Loads directory rows by slot and looks up a picture id by binary search
// over the first entry_count rows, returning the row's size, flags, offsets
// and transparent color.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 payload      direction
//   -------   -----------------------   ----------   ---------
//   request   in_valid / in_ready       in_data      in
//   response  out_valid / out_ready     out_data     out
//   config    cfg_we                    cfg_idx,     in
//                                       cfg_data
//
// A load request yields no response. A lookup makes at most ceil(log2(n+1))
// probes of the directory RAM over n searched rows, one at a time through
// the single read port of the directory RAM.
// Synchronous reset clears the config registers and control; the directory
// contents are undefined until loaded. A stalled response holds the search
// at its final compare until the output register frees up.
// ----------------------------------------------------------------------------
module picture_directory_lookup_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [pdl_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pdl_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pdl_pkg::pdl_req_t               in_data,
  // response
  output logic                            out_valid,
  input  logic                            out_ready,
  output pdl_pkg::pdl_rsp_t               out_data
);
  import pdl_pkg::*;

  pdl_cmd_t cmd;
  pdl_sts_t sts;

  // Controller: owns both handshakes, sequences the probes
  pdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (in_data.func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: config registers, directory RAM, search window, output register
  pdl_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .req      (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .rsp      (out_data)
  );

endmodule
